### rtl/cbr_pkg.sv
// shared types and constants of the cpu bus memory / io responder
// no dependencies; every other file but cbr_ram takes names from here
`default_nettype none

package cbr_pkg;

  // memory address width; the byte store holds 2**ADDR_WIDTH entries
  localparam int unsigned ADDR_WIDTH = 16;
  localparam int unsigned MEM_DEPTH  = 1 << ADDR_WIDTH;

  // command queue between classifier and executor (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // strobe bit positions in the control pins (all active low)
  localparam int unsigned STB_MREQ = 0;
  localparam int unsigned STB_IORQ = 1;
  localparam int unsigned STB_RD   = 2;
  localparam int unsigned STB_WR   = 3;
  localparam int unsigned STB_M1   = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_DATA_PORT = 2'd0;
  localparam logic [1:0] CFG_CHAR_PORT = 2'd1;
  localparam logic [1:0] CFG_IO_VALUE  = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] DATA_PORT_RESET = 16'hFF81;
  localparam logic [15:0] CHAR_PORT_RESET = 16'hFF83;
  localparam logic [7:0]  IO_VALUE_RESET  = 8'h00;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DRIVE   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EVT_NONE = 2'd0,
    EVT_DATA = 2'd1,
    EVT_CHAR = 2'd2
  } evt_e;

  typedef enum logic {
    SRC_MEM = 1'b0,
    SRC_IO  = 1'b1
  } drv_src_e;

  typedef struct packed {
    logic [15:0] data_port;
    logic [15:0] char_port;
    logic [7:0]  io_value;
  } cfg_t;

  // one classified bus sample, as carried through the queue
  typedef struct packed {
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_WIDTH-1:0] addr;
    logic [7:0]            data;
    action_e               action;
    drv_src_e              src;
    evt_e                  evt;
    logic                  fetch0;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/cpu_bus_memory_io_responder.sv
// top level of the cpu bus memory / io responder
// depends on cbr_pkg, cbr_front, cbr_cmd_fifo, cbr_back (and cbr_ram below it)
`default_nettype none

// Each transaction on the input channel is one sample of an 8-bit CPU's bus
// pins (active-low mreq, iorq, rd, wr, m1, the address and the data byte);
// each one yields exactly one result transaction, in order. Falling wr under
// mreq stores the byte, falling rd under mreq drives the stored byte, rising
// mreq releases the bus; the io side works alike, reports writes to the data
// and character ports and drives io_value for any io read, and its bus
// action wins over the memory one. After reset the 64 KiB byte memory is
// cleared one byte per cycle, and in_ready_o stays low until all of its
// 2**ADDR_WIDTH (65536) bytes are clear; configuration writes are taken
// at any time. After that one sample is accepted every cycle while the
// result side keeps up: the front end classifies in the accept cycle, a
// two-entry queue decouples it from the back end, and the back end makes
// one access per cycle to the single write/read port pair of the memory.
// Each result passes through a queue entry and the result register.

module cpu_bus_memory_io_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // bus sample channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  control_pins_i,
  input  wire logic [15:0] bus_address_i,
  input  wire logic [7:0]  bus_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       bus_action_o,
  output logic [7:0]       drive_byte_o,
  output logic [1:0]       port_event_o,
  output logic [7:0]       port_byte_o,
  output logic             fetch_at_zero_o
);

  cbr_pkg::cfg_t cfg_q, cfg_d;
  cbr_pkg::cmd_t push_cmd, head_cmd;
  logic          q_full, q_valid, q_push, q_pop, clearing;

  // configuration registers, always ready; an unknown index is dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        cbr_pkg::CFG_DATA_PORT: cfg_d.data_port = cfg_data_i;
        cbr_pkg::CFG_CHAR_PORT: cfg_d.char_port = cfg_data_i;
        cbr_pkg::CFG_IO_VALUE:  cfg_d.io_value  = cfg_data_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_port <= cbr_pkg::DATA_PORT_RESET;
      cfg_q.char_port <= cbr_pkg::CHAR_PORT_RESET;
      cfg_q.io_value  <= cbr_pkg::IO_VALUE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: edge detection against the last strobes, classification
  cbr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .control_pins_i (control_pins_i),
    .bus_address_i  (bus_address_i),
    .bus_data_i     (bus_data_i),
    .cfg_i          (cfg_q),
    .q_ready_i      (!q_full && !clearing),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  // decoupling queue
  cbr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // back end: clearing pass, memory access, result register
  cbr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (q_pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bus_action_o    (bus_action_o),
    .drive_byte_o    (drive_byte_o),
    .port_event_o    (port_event_o),
    .port_byte_o     (port_byte_o),
    .fetch_at_zero_o (fetch_at_zero_o)
  );

  // a command never both writes and reads the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !(head_cmd.mem_we && head_cmd.mem_re))
    else $error("command both writes and reads memory");

  // nothing reaches the back end while the memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !q_valid && !out_valid_o)
    else $error("work in flight during clearing pass");

  // a soft-reset fetch always moves the data bus (drive, or an io release over it)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fetch_at_zero_o |-> bus_action_o != cbr_pkg::ACT_NONE)
    else $error("fetch at zero without a bus action");

  // a stalled result keeps its drive byte, including memory read data (an io drive follows io_value)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(drive_byte_o))
    else $error("drive byte changed while stalled");

endmodule

`default_nettype wire

### rtl/cbr_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module cbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/cbr_front.sv
// front end: strobe edge detection and classification of each bus sample
// depends on cbr_pkg
`default_nettype none

module cbr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [4:0]    control_pins_i,
  input  wire logic [15:0]   bus_address_i,
  input  wire logic [7:0]    bus_data_i,
  input  wire cbr_pkg::cfg_t cfg_i,
  input  wire logic          q_ready_i,
  output logic               q_push_o,
  output cbr_pkg::cmd_t      q_cmd_o
);

  logic [3:0]       prev_q, prev_d;
  logic [3:0]       now;
  logic             mreq_low, iorq_low;
  logic             wr_fall, rd_fall, mreq_rise, iorq_rise;
  cbr_pkg::action_e mem_act, io_act;
  cbr_pkg::evt_e    evt;

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

  always_comb begin
    now       = control_pins_i[3:0];
    mreq_low  = !now[cbr_pkg::STB_MREQ];
    iorq_low  = !now[cbr_pkg::STB_IORQ];
    wr_fall   = !now[cbr_pkg::STB_WR] && prev_q[cbr_pkg::STB_WR];
    rd_fall   = !now[cbr_pkg::STB_RD] && prev_q[cbr_pkg::STB_RD];
    mreq_rise = now[cbr_pkg::STB_MREQ] && !prev_q[cbr_pkg::STB_MREQ];
    iorq_rise = now[cbr_pkg::STB_IORQ] && !prev_q[cbr_pkg::STB_IORQ];

    // memory side
    mem_act = cbr_pkg::ACT_NONE;
    if (mreq_low) begin
      if (!wr_fall && rd_fall) begin
        mem_act = cbr_pkg::ACT_DRIVE;
      end
    end else if (mreq_rise) begin
      mem_act = cbr_pkg::ACT_RELEASE;
    end

    // io side, takes priority on the bus
    io_act = cbr_pkg::ACT_NONE;
    evt    = cbr_pkg::EVT_NONE;
    if (iorq_low) begin
      if (wr_fall) begin
        if (bus_address_i == cfg_i.data_port) begin
          evt = cbr_pkg::EVT_DATA;
        end else if (bus_address_i == cfg_i.char_port) begin
          evt = cbr_pkg::EVT_CHAR;
        end
      end else if (rd_fall) begin
        io_act = cbr_pkg::ACT_DRIVE;
      end
    end else if (iorq_rise) begin
      io_act = cbr_pkg::ACT_RELEASE;
    end

    q_cmd_o.mem_we = mreq_low && wr_fall;
    q_cmd_o.mem_re = mreq_low && !wr_fall && rd_fall;
    q_cmd_o.addr   = bus_address_i[cbr_pkg::ADDR_WIDTH-1:0];
    q_cmd_o.data   = bus_data_i;
    q_cmd_o.action = (io_act != cbr_pkg::ACT_NONE) ? io_act : mem_act;
    q_cmd_o.src    = (io_act == cbr_pkg::ACT_DRIVE) ? cbr_pkg::SRC_IO : cbr_pkg::SRC_MEM;
    q_cmd_o.evt    = evt;
    q_cmd_o.fetch0 = mreq_low && !wr_fall && rd_fall
                     && !control_pins_i[cbr_pkg::STB_M1] && (bus_address_i == 16'h0000);

    prev_d = q_push_o ? now : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 4'hF;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cbr_cmd_fifo.sv
// short command queue between front end and back end
// depends on cbr_pkg
`default_nettype none

module cbr_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cbr_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output cbr_pkg::cmd_t      cmd_o
);

  cbr_pkg::cmd_t                    entry_q [cbr_pkg::QUEUE_DEPTH];
  logic [cbr_pkg::QPTR_WIDTH-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [cbr_pkg::QCNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                             do_pop;

  assign full_o  = (cnt_q == cbr_pkg::QCNT_WIDTH'(cbr_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/cbr_back.sv
// back end: memory clearing pass, memory access and result register
// depends on cbr_pkg and cbr_ram
`default_nettype none

module cbr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cbr_pkg::cfg_t cfg_i,
  input  wire logic          q_valid_i,
  input  wire cbr_pkg::cmd_t q_cmd_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         bus_action_o,
  output logic [7:0]         drive_byte_o,
  output logic [1:0]         port_event_o,
  output logic [7:0]         port_byte_o,
  output logic               fetch_at_zero_o
);

  logic                          clr_busy_q, clr_busy_d;
  logic [cbr_pkg::ADDR_WIDTH-1:0] clr_addr_q, clr_addr_d;
  logic                          out_valid_q, out_valid_d;
  cbr_pkg::cmd_t                 out_q;
  logic                          ram_we;
  logic [cbr_pkg::ADDR_WIDTH-1:0] ram_waddr;
  logic [7:0]                    ram_wdata, ram_rdata;

  assign clearing_o = clr_busy_q;
  assign q_pop_o    = q_valid_i && !clr_busy_q && (!out_valid_q || out_ready_i);

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == {cbr_pkg::ADDR_WIDTH{1'b1}}) begin
        clr_busy_d = 1'b0;
      end
    end
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    ram_we    = clr_busy_q || (q_pop_o && q_cmd_i.mem_we);
    ram_waddr = clr_busy_q ? clr_addr_q : q_cmd_i.addr;
    ram_wdata = clr_busy_q ? 8'h00 : q_cmd_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_cmd_i;
    end
  end

  cbr_ram #(
    .WIDTH (8),
    .DEPTH (cbr_pkg::MEM_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (q_pop_o && q_cmd_i.mem_re),
    .raddr_i (q_cmd_i.addr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign bus_action_o    = out_q.action;
  assign drive_byte_o    = (out_q.action != cbr_pkg::ACT_DRIVE) ? 8'h00 :
                           (out_q.src == cbr_pkg::SRC_IO) ? cfg_i.io_value : ram_rdata;
  assign port_event_o    = out_q.evt;
  assign port_byte_o     = (out_q.evt != cbr_pkg::EVT_NONE) ? out_q.data : 8'h00;
  assign fetch_at_zero_o = out_q.fetch0;

endmodule

`default_nettype wire

### test/bus_response_checker.sv
`timescale 1ns / 1ps
// checker for the cpu bus memory / io responder: tracks configuration,
// predicts one response per bus sample and compares. depends on cbr_pkg
module bus_response_checker
  import cbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [4:0]  control_pins_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  bus_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  bus_action_i,
  input  logic [7:0]  drive_byte_i,
  input  logic [1:0]  port_event_i,
  input  logic [7:0]  port_byte_i,
  input  logic        fetch_at_zero_i,
  output int          mismatches_o,
  output int          pending_o
);

  typedef struct packed {
    action_e    action;
    logic [7:0] drive;
    evt_e       evt;
    logic [7:0] pbyte;
    logic       fetch0;
  } bus_response_t;

  logic [15:0]   data_port;
  logic [15:0]   char_port;
  logic [7:0]    io_value;
  logic [3:0]    last_strobes;
  logic [7:0]    mem_image [0:MEM_DEPTH-1];
  bus_response_t expected_responses [$];
  bus_response_t want;
  bus_response_t got;
  int            response_index;
  int            k;

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    if (mismatches_o < 30)
      $display("mismatch on response %0d: %s is %0h, expected %0h", response_index, what,
               seen, wanted);
    mismatches_o++;
  endtask

  // one bus sample: edge detect against the last strobes, memory side first
  task automatic predict_bus_response(input logic [4:0] pins, input logic [15:0] addr,
                                      input logic [7:0] data, output bus_response_t r);
    logic [3:0]            now;
    logic [3:0]            changed;
    logic                  wr_fell;
    logic                  rd_fell;
    logic [ADDR_WIDTH-1:0] slot;
    now     = pins[3:0];
    changed = last_strobes ^ now;
    wr_fell = !now[STB_WR] && changed[STB_WR];
    rd_fell = !now[STB_RD] && changed[STB_RD];
    slot    = addr[ADDR_WIDTH-1:0];
    last_strobes = now;
    r = '{ACT_NONE, 8'h00, EVT_NONE, 8'h00, 1'b0};

    if (!now[STB_MREQ]) begin
      if (wr_fell) begin
        mem_image[slot] = data;
      end else if (rd_fell) begin
        r.action = ACT_DRIVE;
        r.drive  = mem_image[slot];
        r.fetch0 = !pins[STB_M1] && addr == 16'h0000;
      end
    end else if (changed[STB_MREQ]) begin
      r.action = ACT_RELEASE;
    end

    // io side overrides any memory bus action
    if (!now[STB_IORQ]) begin
      if (wr_fell) begin
        if (addr == data_port) begin
          r.evt   = EVT_DATA;
          r.pbyte = data;
        end else if (addr == char_port) begin
          r.evt   = EVT_CHAR;
          r.pbyte = data;
        end
      end else if (rd_fell) begin
        r.action = ACT_DRIVE;
        r.drive  = io_value;
      end
    end else if (changed[STB_IORQ]) begin
      r.action = ACT_RELEASE;
    end

    if (r.action != ACT_DRIVE) r.drive = 8'h00;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_port    = DATA_PORT_RESET;
      char_port    = CHAR_PORT_RESET;
      io_value     = IO_VALUE_RESET;
      last_strobes = 4'hF;
      for (k = 0; k < MEM_DEPTH; k++) mem_image[k] = 8'h00;
      expected_responses.delete();
      response_index = 0;
      mismatches_o   = 0;
      pending_o      = 0;
    end else begin
      // responses first: a response never leaves in its own sample's cycle
      if (out_valid_i && out_ready_i) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected response, bus_action", bus_action_i, 0);
        end else begin
          want = expected_responses.pop_front();
          if (bus_action_i !== want.action)
            report_mismatch("bus_action", bus_action_i, want.action);
          if (drive_byte_i !== want.drive)
            report_mismatch("drive_byte", drive_byte_i, want.drive);
          if (port_event_i !== want.evt)
            report_mismatch("port_event", port_event_i, want.evt);
          if (port_byte_i !== want.pbyte)
            report_mismatch("port_byte", port_byte_i, want.pbyte);
          if (fetch_at_zero_i !== want.fetch0)
            report_mismatch("fetch_at_zero", fetch_at_zero_i, want.fetch0);
        end
        response_index++;
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DATA_PORT: data_port = cfg_data_i;
          CFG_CHAR_PORT: char_port = cfg_data_i;
          CFG_IO_VALUE:  io_value  = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        predict_bus_response(control_pins_i, bus_address_i, bus_data_i, got);
        expected_responses.push_back(got);
      end

      pending_o = expected_responses.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// testbench top for the cpu bus memory / io responder: clock, reset, stimulus
// and verdict. depends on cbr_pkg, the responder rtl and bus_response_checker
module tb;
  import cbr_pkg::*;

  // pin patterns, bits are {m1, wr, rd, iorq, mreq}, all active low
  localparam logic [4:0] PINS_IDLE  = 5'b11111;
  localparam logic [4:0] PINS_MEM   = 5'b11110;
  localparam logic [4:0] PINS_MEMWR = 5'b10110;
  localparam logic [4:0] PINS_MEMRD = 5'b11010;
  localparam logic [4:0] PINS_FETCH = 5'b01010;
  localparam logic [4:0] PINS_IO    = 5'b11101;
  localparam logic [4:0] PINS_IOWR  = 5'b10101;
  localparam logic [4:0] PINS_IORD  = 5'b11001;

  // index past the last register, writes to it must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // room for the reset clear of all 64k bytes and ~1100 samples with stalls
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  control_pins_i = PINS_IDLE;
  logic [15:0] bus_address_i = '0;
  logic [7:0]  bus_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  bus_action_o;
  logic [7:0]  drive_byte_o;
  logic [1:0]  port_event_o;
  logic [7:0]  port_byte_o;
  logic        fetch_at_zero_o;

  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  int          samples_sent = 0;
  int          burst_left = 0;
  logic [15:0] cur_data_port = DATA_PORT_RESET;
  logic [15:0] cur_char_port = CHAR_PORT_RESET;
  logic [15:0] window_base = 16'h0100;
  logic        hold_off_req = 1'b0;
  logic        hold_off_done = 1'b0;

  cpu_bus_memory_io_responder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .control_pins_i  (control_pins_i),
    .bus_address_i   (bus_address_i),
    .bus_data_i      (bus_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bus_action_o    (bus_action_o),
    .drive_byte_o    (drive_byte_o),
    .port_event_o    (port_event_o),
    .port_byte_o     (port_byte_o),
    .fetch_at_zero_o (fetch_at_zero_o)
  );

  bus_response_checker resp_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .control_pins_i  (control_pins_i),
    .bus_address_i   (bus_address_i),
    .bus_data_i      (bus_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bus_action_i    (bus_action_o),
    .drive_byte_i    (drive_byte_o),
    .port_event_i    (port_event_o),
    .port_byte_i     (port_byte_o),
    .fetch_at_zero_i (fetch_at_zero_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog, also catches responses that never turn up
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[cpu_bus_memory_io_responder] ERROR");
      $finish;
    end
  end

  // response side: stall patterns of random length, plus one long hold-off
  // so that the queue fills and the input side backs up
  initial begin : result_sink
    int mode;
    int span;
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 120);
        repeat (span) begin
          @(negedge clk_i);
          case (mode)
            0:       out_ready_i = 1'b1;
            1:       out_ready_i = $urandom_range(0, 1);
            2:       out_ready_i = ($urandom_range(0, 3) == 0);
            default: out_ready_i = ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  // one bus sample transaction; bursts keep valid high back to back,
  // a gap may drop it before the next burst
  task automatic push_sample(input logic [4:0] pins, input logic [15:0] addr,
                             input logic [7:0] data);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    control_pins_i = pins;
    bus_address_i  = addr;
    bus_data_i     = data;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    samples_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] index, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stop sending, let every response come back, then reprogram the registers
  task automatic reconfigure(input logic [15:0] dport, input logic [15:0] cport,
                             input logic [15:0] io_word);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    cfg_write(CFG_DATA_PORT, dport);
    cfg_write(CFG_CHAR_PORT, cport);
    cfg_write(CFG_IO_VALUE, io_word);
    cfg_write(CFG_UNUSED, 16'($urandom));
    cur_data_port = dport;
    cur_char_port = cport;
    window_base   = 16'($urandom);
  endtask

  // mostly a small window so reads hit bytes written earlier
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return window_base + 16'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cur_data_port;
      4, 5, 6:    return cur_char_port;
      default:    return pick_addr();
    endcase
  endfunction

  // one machine cycle: mostly well-formed, some cut short, some pure noise
  task automatic run_bus_cycle();
    logic [4:0]  step_pins [4];
    logic [15:0] addr;
    logic [7:0]  data;
    int          n;
    int          k;
    logic        broken;
    n      = 0;
    broken = 1'b0;
    data   = 8'($urandom);
    addr   = pick_addr();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        step_pins[0] = PINS_MEM;
        step_pins[1] = PINS_MEMWR;
        step_pins[2] = PINS_MEM;
        step_pins[3] = PINS_IDLE;
        n = 4;
      end
      5, 6, 7, 8, 9: begin
        step_pins[0] = PINS_MEMRD;
        if ($urandom_range(0, 2) == 0) step_pins[0][STB_M1] = 1'b0;
        step_pins[1] = PINS_IDLE;
        n = 2;
      end
      10, 11, 12: begin
        addr = pick_port();
        step_pins[0] = PINS_IO;
        step_pins[1] = PINS_IOWR;
        step_pins[2] = PINS_IO;
        step_pins[3] = PINS_IDLE;
        n = 4;
      end
      13, 14: begin
        step_pins[0] = PINS_IORD;
        step_pins[1] = PINS_IDLE;
        n = 2;
      end
      default: ;
    endcase
    if (n > 0 && $urandom_range(0, 7) == 0) begin
      broken = 1'b1;
      n = $urandom_range(1, n);
    end
    for (k = 0; k < n; k++) push_sample(step_pins[k], addr, data);
    if (n == 0 || broken) begin
      repeat ($urandom_range(1, 3))
        push_sample(5'($urandom_range(0, 31)), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset configuration
    push_sample(PINS_IDLE,  16'h0000, 8'h00);
    push_sample(PINS_MEM,   16'hFFFF, 8'hFF);
    push_sample(PINS_MEMWR, 16'hFFFF, 8'hFF);   // store at top of memory
    push_sample(PINS_MEM,   16'hFFFF, 8'hFF);
    push_sample(PINS_IDLE,  16'hFFFF, 8'hFF);   // mreq rises: release
    push_sample(PINS_MEMRD, 16'hFFFF, 8'h00);   // read back
    push_sample(PINS_IDLE,  16'hFFFF, 8'h00);
    push_sample(PINS_FETCH, 16'h0000, 8'h00);   // opcode fetch at zero
    push_sample(PINS_IDLE,  16'h0000, 8'h00);
    push_sample(PINS_IO,    DATA_PORT_RESET, 8'hA5);
    push_sample(PINS_IOWR,  DATA_PORT_RESET, 8'hA5);   // data port write
    push_sample(PINS_IDLE,  DATA_PORT_RESET, 8'hA5);   // iorq rises: release
    push_sample(PINS_IOWR,  CHAR_PORT_RESET, 8'h5A);   // char port, iorq and wr together
    push_sample(PINS_IDLE,  CHAR_PORT_RESET, 8'h5A);
    push_sample(PINS_IORD,  16'h1234, 8'h00);          // io read returns fixed byte
    push_sample(PINS_IDLE,  16'h1234, 8'h00);
    push_sample(5'b10010,   16'h0100, 8'h3C);   // wr and rd fall together: write wins
    push_sample(PINS_IDLE,  16'h0100, 8'h3C);
    push_sample(PINS_MEMRD, 16'h0100, 8'h00);
    push_sample(PINS_IDLE,  16'h0100, 8'h00);
    push_sample(5'b10100,   DATA_PORT_RESET, 8'h77);   // both requests with write
    push_sample(5'b11000,   DATA_PORT_RESET, 8'h00);   // both with read: io drive wins
    push_sample(PINS_IDLE,  DATA_PORT_RESET, 8'h00);
    push_sample(5'b00000,   16'h0000, 8'h00);   // every strobe low at once
    push_sample(PINS_IDLE,  16'h0000, 8'h00);

    // random phases over several register settings, extremes included;
    // the io value writes carry upper bits that must be masked off
    reconfigure(16'h0000, 16'hFFFF, 16'hFFFF);
    while (samples_sent < 295) run_bus_cycle();

    reconfigure(16'hC0DE, 16'hC0DE, 16'($urandom));   // same port in both registers
    hold_off_req = 1'b1;
    while (samples_sent < 565) run_bus_cycle();

    reconfigure(16'hFFFF, 16'h0000, 16'hFF00);
    while (samples_sent < 835) run_bus_cycle();

    reconfigure(16'($urandom), 16'($urandom), 16'($urandom));
    while (samples_sent < 1100) run_bus_cycle();

    // drain, then give stray responses a chance to show up
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("[cpu_bus_memory_io_responder] OK");
    else
      $display("[cpu_bus_memory_io_responder] ERROR");
    $finish;
  end

endmodule

### cpu_bus_memory_io_responder.f
rtl/cbr_pkg.sv
rtl/cbr_ram.sv
rtl/cbr_front.sv
rtl/cbr_cmd_fifo.sv
rtl/cbr_back.sv
rtl/cpu_bus_memory_io_responder.sv
test/bus_response_checker.sv
test/tb.sv
